@@ sv/dhfe_pkg.sv @@
package dhfe_pkg;

  localparam int NUM_FIELDS = 4;
  localparam int MAX_CHARS  = 64;
  localparam int IDX_W      = 6;
  localparam int SIG_LEN    = 16;

  // Expected signature at the head of the sector, byte 0 first.
  localparam logic [7:0] SIG_BYTES [SIG_LEN] = '{
    8'h53, 8'h45, 8'h47, 8'h41, 8'h44, 8'h49, 8'h53, 8'h43,
    8'h53, 8'h59, 8'h53, 8'h54, 8'h45, 8'h4D, 8'h20, 8'h20
  };

  // Sector offsets of domestic title, overseas title, product code, region.
  localparam int unsigned FIELD_BASE [NUM_FIELDS] = '{32'h120, 32'h150, 32'h180, 32'h1F0};

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  localparam logic REQ_HEADER = 1'b0;
  localparam logic REQ_READ   = 1'b1;

  localparam logic REPLY_STATUS = 1'b0;
  localparam logic REPLY_FIELD  = 1'b1;

  localparam logic [15:0] STATUS_VALID = 16'd1;
  localparam logic [15:0] STATUS_BAD   = 16'd2;

endpackage

@@ sv/disc_header_field_extractor_core.sv @@
// Disc header field extractor. Input words carry either one header byte (tuser 0) or a
// field read (tuser 1). A word that is taken sits in the input register; when it moves
// on, its reply lands in the output register: the parse status, or the two field bytes
// from a registered read of the field memories. Words flow at one per clock while the
// input does not stall. The input stalls only when the word in the input register has a
// reply of its own and the receiver is still holding the previous one. The last byte of
// each header returns the parse status (1 valid, 2 bad signature); other header bytes
// return nothing. A read returns two field bytes packed big-endian, with positions at or
// past the trimmed field length reading as zero. The field memories need no clearing
// after reset.
module disc_header_field_extractor_core #(
  parameter int HEADER_BYTES  = 512,
  parameter int TITLE_CHARS   = 48,
  parameter int PRODUCT_CHARS = 14,
  parameter int REGION_CHARS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // header_byte[7:0], header_start[8], field_select[10:9], word_index[18:11], zero pad
  input  logic [23:0] s_tdata,
  // req_type[0]
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // reply_value[15:0]
  output logic [15:0] m_tdata,
  // reply_kind[0]
  output logic        m_tuser
);
  import dhfe_pkg::*;

  localparam int PosW = $clog2(HEADER_BYTES + 1);
  localparam int unsigned FieldCap [NUM_FIELDS] = '{
    TITLE_CHARS, TITLE_CHARS, PRODUCT_CHARS, REGION_CHARS
  };

  // Input register.
  logic             s1_valid;
  logic             s1_type;
  logic [7:0]       s1_byte;
  logic             s1_start;
  logic [1:0]       s1_fsel;
  logic [7:0]       s1_widx;

  // Parse state.
  logic [PosW-1:0]  pos;
  logic             sig_ok;
  logic [IDX_W-1:0] cnt      [NUM_FIELDS];
  logic [IDX_W-1:0] trim     [NUM_FIELDS];
  logic             stopped  [NUM_FIELDS];

  logic [PosW-1:0]  pos_next;
  logic             sig_ok_next;
  logic [IDX_W-1:0] cnt_next     [NUM_FIELDS];
  logic [IDX_W-1:0] trim_next    [NUM_FIELDS];
  logic             stopped_next [NUM_FIELDS];

  logic             wr_en   [NUM_FIELDS];
  logic [IDX_W-1:0] wr_addr [NUM_FIELDS];
  logic [7:0]       wr_char;

  // Output register.
  logic             out_valid;
  logic             out_kind;
  logic [15:0]      out_status;
  logic [1:0]       out_fsel;
  logic             out_hi_ok;
  logic             out_lo_ok;
  logic [7:0]       rd_hi [NUM_FIELDS];
  logic [7:0]       rd_lo [NUM_FIELDS];

  logic             begin_hdr;
  logic [PosW-1:0]  pos_e;
  logic             is_last;
  logic             has_result;
  logic             out_free;
  logic             s1_go;
  logic             rd_en;
  logic [8:0]       rd_off;
  logic [8:0]       rd_off_p1;
  logic [IDX_W-1:0] fsel_trim;

  assign is_last    = (pos_e == PosW'(HEADER_BYTES - 1));
  assign has_result = (s1_type == REQ_READ) || is_last;
  assign out_free   = !out_valid || m_tready;
  assign s1_go      = s1_valid && (!has_result || out_free);
  assign s_tready   = !s1_valid || s1_go;
  assign rd_en      = s1_go && (s1_type == REQ_READ);

  assign rd_off    = {s1_widx, 1'b0};
  assign rd_off_p1 = {s1_widx, 1'b1};
  assign fsel_trim = trim[s1_fsel];

  // A new header begins on a start mark or on any byte after a finished header.
  always_comb begin
    begin_hdr   = s1_start || (pos >= PosW'(HEADER_BYTES));
    pos_e       = begin_hdr ? '0 : pos;
    sig_ok_next = begin_hdr ? 1'b1 : sig_ok;
    if ((pos_e < PosW'(SIG_LEN)) && (s1_byte != SIG_BYTES[pos_e[3:0]])) begin
      sig_ok_next = 1'b0;
    end
    wr_char = ((s1_byte >= CHAR_SPACE) && (s1_byte <= CHAR_TILDE)) ? s1_byte : CHAR_SPACE;
    pos_next = is_last ? PosW'(HEADER_BYTES) : pos_e + PosW'(1);
    for (int f = 0; f < NUM_FIELDS; f++) begin
      cnt_next[f]     = begin_hdr ? '0 : cnt[f];
      trim_next[f]    = begin_hdr ? '0 : trim[f];
      stopped_next[f] = begin_hdr ? 1'b0 : stopped[f];
      wr_addr[f]      = cnt_next[f];
      wr_en[f]        = 1'b0;
      if (sig_ok_next && (int'(pos_e) >= FIELD_BASE[f]) &&
          (int'(pos_e) < FIELD_BASE[f] + FieldCap[f]) &&
          !stopped_next[f] && (int'(cnt_next[f]) < FieldCap[f])) begin
        if (s1_byte == 8'h00) begin
          stopped_next[f] = 1'b1;
        end else begin
          wr_en[f]    = 1'b1;
          cnt_next[f] = cnt_next[f] + IDX_W'(1);
          if (wr_char != CHAR_SPACE) begin
            trim_next[f] = cnt_next[f];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      s1_type  <= s_tuser;
      s1_byte  <= s_tdata[7:0];
      s1_start <= s_tdata[8];
      s1_fsel  <= s_tdata[10:9];
      s1_widx  <= s_tdata[18:11];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      sig_ok <= 1'b1;
      for (int f = 0; f < NUM_FIELDS; f++) begin
        cnt[f]     <= '0;
        trim[f]    <= '0;
        stopped[f] <= 1'b0;
      end
    end else if (s1_go && (s1_type == REQ_HEADER)) begin
      pos    <= pos_next;
      sig_ok <= sig_ok_next;
      for (int f = 0; f < NUM_FIELDS; f++) begin
        cnt[f]     <= cnt_next[f];
        trim[f]    <= trim_next[f];
        stopped[f] <= stopped_next[f];
      end
    end
  end

  for (genvar g = 0; g < NUM_FIELDS; g++) begin : g_field
    logic [7:0] fmem [MAX_CHARS];

    always_ff @(posedge clk) begin
      if (s1_go && (s1_type == REQ_HEADER) && wr_en[g]) begin
        fmem[wr_addr[g]] <= wr_char;
      end
      if (rd_en) begin
        rd_hi[g] <= fmem[rd_off[IDX_W-1:0]];
        rd_lo[g] <= fmem[rd_off_p1[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_go && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && has_result) begin
      out_kind   <= (s1_type == REQ_READ) ? REPLY_FIELD : REPLY_STATUS;
      out_status <= sig_ok_next ? STATUS_VALID : STATUS_BAD;
      out_fsel   <= s1_fsel;
      out_hi_ok  <= rd_off < {3'b000, fsel_trim};
      out_lo_ok  <= rd_off_p1 < {3'b000, fsel_trim};
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_kind;
  assign m_tdata  = (out_kind == REPLY_FIELD) ?
                    {out_hi_ok ? rd_hi[out_fsel] : 8'h00,
                     out_lo_ok ? rd_lo[out_fsel] : 8'h00} : out_status;

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PosW'(HEADER_BYTES))
    else $error("byte position past the header length");

  a_trim_le_cnt: assert property (@(posedge clk) disable iff (rst)
    (trim[0] <= cnt[0]) && (trim[1] <= cnt[1]) && (trim[2] <= cnt[2]) && (trim[3] <= cnt[3]))
    else $error("trimmed length exceeds copied count");

  a_bad_sig_empty: assert property (@(posedge clk) disable iff (rst)
    !sig_ok |-> (trim[0] == '0) && (trim[1] == '0) && (trim[2] == '0) && (trim[3] == '0))
    else $error("field captured under a bad signature");

  a_status_on_last: assert property (@(posedge clk) disable iff (rst)
    (s1_go && (s1_type == REQ_HEADER) && is_last) |=> m_tvalid && (m_tuser == REPLY_STATUS))
    else $error("last header byte gave no status");

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps
module testbench;
  import dhfe_pkg::*;

  localparam int HEADER_BYTES  = 512;
  localparam int TITLE_CHARS   = 48;
  localparam int PRODUCT_CHARS = 14;
  localparam int REGION_CHARS  = 16;
  localparam int FIELD_CAP [NUM_FIELDS] = '{TITLE_CHARS, TITLE_CHARS, PRODUCT_CHARS, REGION_CHARS};

  typedef struct packed {
    logic        kind;
    logic [15:0] value;
  } reply_t;

  typedef enum int {FILL_TEXT, FILL_TERMINATED, FILL_RAW, FILL_BLANK, FILL_DIRTY} fill_mode_t;
  typedef enum int {SIG_INTACT, SIG_ONE_BAD, SIG_NOISE} sig_style_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_PERIODIC, RX_CHOKED} rx_mode_t;

  class field_extract_scoreboard;
    reply_t     expected_replies [$];
    int unsigned byte_pos;
    bit         sig_ok;
    logic [7:0] field_mem [NUM_FIELDS][MAX_CHARS];
    int         copied [NUM_FIELDS];
    int         trimmed [NUM_FIELDS];
    bit         stopped [NUM_FIELDS];
    int         mismatches;
    int         header_bytes;
    int         reads_checked;
    int         good_headers;
    int         bad_headers;

    function new();
      foreach (field_mem[f, i]) field_mem[f][i] = 8'h00;
      restart_header();
    endfunction

    function void restart_header();
      byte_pos = 0;
      sig_ok   = 1'b1;
      foreach (copied[f]) begin
        copied[f]  = 0;
        trimmed[f] = 0;
        stopped[f] = 1'b0;
      end
    endfunction

    function void absorb_byte(logic [7:0] b);
      logic [7:0] ch;
      if (byte_pos < SIG_LEN && b != SIG_BYTES[byte_pos]) sig_ok = 1'b0;
      if (!sig_ok) return;
      for (int f = 0; f < NUM_FIELDS; f++) begin
        if (byte_pos < FIELD_BASE[f] || byte_pos >= FIELD_BASE[f] + FIELD_CAP[f]) continue;
        if (stopped[f] || copied[f] >= FIELD_CAP[f]) continue;
        if (b == 8'h00) begin
          stopped[f] = 1'b1;
          continue;
        end
        ch = (b >= CHAR_SPACE && b <= CHAR_TILDE) ? b : CHAR_SPACE;
        field_mem[f][copied[f]] = ch;
        copied[f]++;
        // Trailing spaces do not extend the readable length.
        if (ch != CHAR_SPACE) trimmed[f] = copied[f];
      end
    endfunction

    function logic [7:0] field_char(int f, int p);
      if (p >= trimmed[f] || p >= MAX_CHARS) return 8'h00;
      return field_mem[f][p];
    endfunction

    function void note_word(logic user, logic [23:0] data);
      reply_t r;
      int     sel;
      int     widx;
      sel  = data[10:9];
      widx = data[18:11];
      if (user == REQ_READ) begin
        r.kind  = REPLY_FIELD;
        r.value = {field_char(sel, 2 * widx), field_char(sel, 2 * widx + 1)};
        expected_replies.push_back(r);
        return;
      end
      header_bytes++;
      if (data[8] || byte_pos >= HEADER_BYTES) restart_header();
      absorb_byte(data[7:0]);
      if (byte_pos == HEADER_BYTES - 1) begin
        r.kind  = REPLY_STATUS;
        r.value = sig_ok ? STATUS_VALID : STATUS_BAD;
        expected_replies.push_back(r);
        byte_pos = HEADER_BYTES;
      end else begin
        byte_pos++;
      end
    endfunction

    function void check_reply(logic kind, logic [15:0] value);
      reply_t want;
      if (expected_replies.size() == 0) begin
        $error("unexpected reply: reply_kind %0d reply_value 0x%04h", kind, value);
        mismatches++;
        return;
      end
      want = expected_replies.pop_front();
      if (kind !== want.kind) begin
        $error("reply_kind: expected %0d, actual %0d", want.kind, kind);
        mismatches++;
      end
      if (value !== want.value) begin
        $error("reply_value: expected 0x%04h, actual 0x%04h", want.value, value);
        mismatches++;
      end
      if (want.kind == REPLY_FIELD) reads_checked++;
      else if (want.value == STATUS_VALID) good_headers++;
      else bad_headers++;
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    function void flush_check();
      if (expected_replies.size() != 0) begin
        $error("%0d expected replies never arrived", expected_replies.size());
        mismatches += expected_replies.size();
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;
  logic        m_tuser;

  field_extract_scoreboard sb = new();

  logic [7:0] sector [HEADER_BYTES];
  int         burst_left = 0;
  rx_mode_t   rx_mode = RX_OPEN;
  int         rx_left = 0;
  int         rx_phase = 0;

  always #5 clk = ~clk;

  disc_header_field_extractor_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .TITLE_CHARS  (TITLE_CHARS),
    .PRODUCT_CHARS(PRODUCT_CHARS),
    .REGION_CHARS (REGION_CHARS)
  ) uut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

  // The receiver switches among open, coin-flip, periodic and heavily choked stretches.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_t'($urandom_range(0, 3));
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    rx_phase++;
    case (rx_mode)
      RX_OPEN:     m_tready = 1'b1;
      RX_COIN:     m_tready = 1'($urandom_range(0, 1));
      RX_PERIODIC: m_tready = (rx_phase % 5) < 3;
      default:     m_tready = ($urandom_range(0, 11) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_reply(m_tuser, m_tdata);
  end

  function automatic logic [23:0] pack_word(logic [7:0] b, logic start, logic [1:0] sel,
                                            logic [7:0] widx);
    return {5'b0, widx, sel, start, b};
  endfunction

  function automatic logic [7:0] printable_char();
    return 8'($urandom_range(32'h20, 32'h7E));
  endfunction

  function automatic logic [7:0] odd_char();
    case ($urandom_range(0, 2))
      0:       return 8'($urandom_range(1, 31));
      1:       return 8'h7F;
      default: return 8'($urandom_range(128, 255));
    endcase
  endfunction

  // Sends one word; the sender runs in bursts and usually drops tvalid for a while between them.
  task automatic push_word(input logic user, input logic [23:0] data);
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid = 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 400) : $urandom_range(1, 24);
    end
    s_tvalid = 1'b1;
    s_tuser  = user;
    s_tdata  = data;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_word(user, data);
    burst_left--;
    @(negedge clk);
  endtask

  // Header byte and start bit are don't-cares on a read, so they are randomized.
  task automatic read_field(input int sel, input int widx);
    push_word(REQ_READ, pack_word(8'($urandom), 1'($urandom_range(0, 1)), 2'(sel), 8'(widx)));
  endtask

  task automatic read_sweep(input int count);
    repeat (count) begin
      read_field($urandom_range(0, 3),
                 ($urandom_range(0, 7) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 31));
    end
  endtask

  task automatic fill_field(input int f, input fill_mode_t mode);
    int len;
    int at;
    len = $urandom_range(0, FIELD_CAP[f]);
    for (int i = 0; i < FIELD_CAP[f]; i++) begin
      at = FIELD_BASE[f] + i;
      case (mode)
        FILL_TEXT:       sector[at] = (i < len) ? printable_char() : CHAR_SPACE;
        FILL_TERMINATED: sector[at] = (i < len) ? printable_char() :
                                      (i == len) ? 8'h00 : 8'($urandom);
        FILL_RAW:        sector[at] = 8'($urandom);
        FILL_BLANK:      sector[at] = (i == 0 && len[0]) ? 8'h00 : CHAR_SPACE;
        default:         sector[at] = (i < len && $urandom_range(0, 3) != 0) ?
                                      printable_char() : odd_char();
      endcase
    end
  endtask

  task automatic build_sector(input sig_style_t style);
    int bad_pos;
    for (int i = 0; i < HEADER_BYTES; i++) sector[i] = 8'($urandom);
    if (style != SIG_NOISE) begin
      for (int i = 0; i < SIG_LEN; i++) sector[i] = SIG_BYTES[i];
      for (int f = 0; f < NUM_FIELDS; f++) fill_field(f, fill_mode_t'($urandom_range(0, 4)));
    end
    if (style == SIG_ONE_BAD) begin
      bad_pos = $urandom_range(0, SIG_LEN - 1);
      sector[bad_pos] = sector[bad_pos] ^ 8'($urandom_range(1, 255));
    end
  endtask

  // Streams the first cut_at bytes of the sector, with field reads mixed in now and then.
  task automatic stream_header(input bit mark_start, input int cut_at);
    for (int i = 0; i < cut_at; i++) begin
      if ($urandom_range(0, 31) == 0) read_sweep(1);
      push_word(REQ_HEADER, pack_word(sector[i], mark_start && (i == 0), 2'($urandom),
                                      8'($urandom)));
    end
  endtask

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int waited;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tuser  = REQ_HEADER;
    s_tdata  = '0;
    m_tready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Before any header every field is empty, at both ends of the word range.
    for (int f = 0; f < NUM_FIELDS; f++) begin
      read_field(f, 0);
      read_field(f, 255);
    end

    // One full header with a start mark, then every word of every field and one past it.
    build_sector(SIG_INTACT);
    stream_header(1'b1, HEADER_BYTES);
    for (int f = 0; f < NUM_FIELDS; f++) begin
      for (int w = 0; w <= (FIELD_CAP[f] + 1) / 2; w++) read_field(f, w);
    end

    // A short header follows the finished one without a start mark and carries a broken
    // signature, so the fields read back empty from its first byte on.
    build_sector(SIG_ONE_BAD);
    stream_header(1'b0, $urandom_range(SIG_LEN + 1, 4 * SIG_LEN));
    read_sweep(10);

    s_tvalid = 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);
    sb.flush_check();
    $display("Sent %0d header bytes and checked %0d field word reads.", sb.header_bytes,
             sb.reads_checked);
    $display("Headers finished: %0d with a valid signature, %0d with a bad one.",
             sb.good_headers, sb.bad_headers);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
